[design/rgbe_pkg.sv]
`default_nettype none
package rgbe_pkg;

  // Configuration register indexes.
  localparam logic [1:0] CFG_IMAGE_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_IMAGE_HEIGHT = 2'd1;

  // Result status codes.
  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_BAD_MARKER = 3'd1;
  localparam logic [2:0] ST_WIDTH      = 3'd2;
  localparam logic [2:0] ST_ZERO_COUNT = 3'd3;
  localparam logic [2:0] ST_OVERRUN    = 3'd4;

  // Run-length decode phases.
  localparam logic [1:0] PH_COUNT   = 2'd0;
  localparam logic [1:0] PH_RUN     = 2'd1;
  localparam logic [1:0] PH_LITERAL = 2'd2;

  // Planes, and the value a scanline header must open with.
  localparam logic [1:0] PLANE_RED = 2'd0;
  localparam logic [1:0] PLANE_GRN = 2'd1;
  localparam logic [1:0] PLANE_BLU = 2'd2;
  localparam logic [1:0] PLANE_EXP = 2'd3;
  localparam logic [7:0] MARKER    = 8'd2;
  localparam logic [7:0] RUN_BASE  = 8'd128;

  // Sequencer states.
  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_FILL = 8'b0000_0010,
    S_RD1  = 8'b0000_0100,
    S_RD2  = 8'b0000_1000,
    S_RD3  = 8'b0001_0000,
    S_EMIT = 8'b0010_0000,
    S_CHK  = 8'b0100_0000,
    S_ERR  = 8'b1000_0000
  } state_t;

endpackage
`default_nettype wire

[design/rgbe_f32conv.sv]
`default_nettype none
// Exact single-precision bits of mant * 2^(expo - 136); zero mantissa or
// zero exponent gives +0.0.
module rgbe_f32conv (
  input  wire logic [7:0]  mant,
  input  wire logic [7:0]  expo,
  output logic      [31:0] result
);

  logic [2:0]  msb;
  logic [8:0]  sum;
  logic [30:0] shifted;

  always_comb begin
    // Leading one of the mantissa byte.
    msb = '0;
    for (int i = 0; i < 8; i++) begin
      if (mant[i]) begin
        msb = 3'(i);
      end
    end
    sum     = {1'b0, expo} + {6'b0, msb};
    shifted = {23'b0, mant} << (5'd23 - {2'b0, msb});
    if (mant == 8'd0 || expo == 8'd0) begin
      result = '0;
    end else if (sum >= 9'd10) begin
      // Normal number: biased exponent is msb + expo - 9.
      result = {1'b0, 8'(sum - 9'd9), shifted[22:0]};
    end else begin
      // Subnormal: the mantissa lands directly in the fraction field.
      result = {24'b0, mant} << (expo[4:0] + 5'd13);
    end
  end

endmodule
`default_nettype wire

[design/rgbe_rle_scanline_decoder_unit.sv]
`default_nettype none
// Decodes the run-length coded pixel data of a Radiance HDR image, one byte
// per beat, into IEEE single-precision pixels, up to two pixels per output
// beat. A red, green or blue byte that places n values writes them into the
// line store, one write a cycle. An exponent byte reads its pixels through
// the single read port of the line store and waits while the output is
// stalled; so does a byte that raises an error. A new byte is taken only
// once the last one is done. The line store needs no clearing after reset.
// After an error the status beat is sent once and all further bytes are
// dropped until reset.
module rgbe_rle_scanline_decoder_unit #(
  parameter int MAX_WIDTH = 4096
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       out_pixel_count,
  output logic [31:0]      out_first_red,
  output logic [31:0]      out_first_green,
  output logic [31:0]      out_first_blue,
  output logic [31:0]      out_second_red,
  output logic [31:0]      out_second_green,
  output logic [31:0]      out_second_blue,
  output logic             out_last_of_burst,
  output logic             out_line_end,
  output logic             out_image_end,
  output logic [2:0]       out_status
);

  localparam int COLW = $clog2(MAX_WIDTH + 1);
  localparam int AW   = $clog2(MAX_WIDTH);
  localparam int CMPW = (COLW > 13) ? COLW : 13;

  // Line store: red, green and blue of each column.
  logic [23:0] line_mem [MAX_WIDTH];
  logic [23:0] rd_q;
  logic        rd_en;
  logic [AW-1:0] rd_addr;
  logic        wr_en;

  rgbe_pkg::state_t state_r, state_nxt;
  logic [COLW-1:0] col_r, col_nxt;
  logic [1:0]  plane_r, plane_nxt;
  logic [2:0]  hdr_r, hdr_nxt;
  logic [7:0]  whi_r, whi_nxt;
  logic [1:0]  phase_r, phase_nxt;
  logic [7:0]  lit_r, lit_nxt;
  logic [14:0] line_r, line_nxt;
  logic [2:0]  err_r, err_nxt;
  logic [7:0]  cnt_r, cnt_nxt;
  logic [7:0]  val_r, val_nxt;
  logic [12:0] iw_r;
  logic [14:0] ih_r;

  // Pixel holding registers and the output register.
  logic [31:0] h0r_r, h0g_r, h0b_r, h1r_r, h1g_r, h1b_r;
  logic        h0le_r, h0ie_r, h1le_r, h1ie_r, two_r;
  logic        out_valid_r;
  logic [1:0]  o_cnt_r;
  logic [31:0] o0r_r, o0g_r, o0b_r, o1r_r, o1g_r, o1b_r;
  logic        o_last_r, o_le_r, o_ie_r;
  logic [2:0]  o_st_r;

  logic [31:0] f_red, f_grn, f_blu;
  logic [CMPW-1:0] col_ext, iw_ext, rem;
  logic        width_ok, le_now, ie_now, out_free, load_pix, load_err;
  logic [COLW-1:0] col_inc;

  rgbe_f32conv u_cv_red (.mant(rd_q[23:16]), .expo(val_r), .result(f_red));
  rgbe_f32conv u_cv_grn (.mant(rd_q[15:8]),  .expo(val_r), .result(f_grn));
  rgbe_f32conv u_cv_blu (.mant(rd_q[7:0]),   .expo(val_r), .result(f_blu));

  assign in_ready  = (state_r == rgbe_pkg::S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid_r || out_ready;

  assign col_ext  = CMPW'(col_r);
  assign iw_ext   = CMPW'(iw_r);
  assign col_inc  = col_r + 1'b1;
  assign width_ok = (iw_r != 13'd0) && ({19'b0, iw_r} <= 32'(MAX_WIDTH));
  assign rem      = (col_ext < iw_ext) ? iw_ext - col_ext : '0;
  assign le_now   = (col_ext + 1'b1 == iw_ext);
  assign ie_now   = le_now && (line_r + 15'd1 == ih_r);

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    col_nxt   = col_r;
    plane_nxt = plane_r;
    hdr_nxt   = hdr_r;
    whi_nxt   = whi_r;
    phase_nxt = phase_r;
    lit_nxt   = lit_r;
    line_nxt  = line_r;
    err_nxt   = err_r;
    cnt_nxt   = cnt_r;
    val_nxt   = val_r;
    rd_en     = 1'b0;
    rd_addr   = col_r[AW-1:0];
    wr_en     = 1'b0;
    load_pix  = 1'b0;
    load_err  = 1'b0;
    case (state_r)
      rgbe_pkg::S_IDLE: begin
        if (in_valid && err_r == rgbe_pkg::ST_OK) begin
          if (hdr_r < 3'd2) begin
            if (in_data_byte != rgbe_pkg::MARKER) begin
              err_nxt   = rgbe_pkg::ST_BAD_MARKER;
              state_nxt = rgbe_pkg::S_ERR;
            end else begin
              hdr_nxt = hdr_r + 3'd1;
            end
          end else if (hdr_r == 3'd2) begin
            whi_nxt = in_data_byte;
            hdr_nxt = 3'd3;
          end else if (hdr_r == 3'd3) begin
            if (!width_ok || {whi_r, in_data_byte} != {3'b0, iw_r}) begin
              err_nxt   = rgbe_pkg::ST_WIDTH;
              state_nxt = rgbe_pkg::S_ERR;
            end else begin
              hdr_nxt   = 3'd4;
              plane_nxt = rgbe_pkg::PLANE_RED;
              col_nxt   = '0;
              phase_nxt = rgbe_pkg::PH_COUNT;
              lit_nxt   = '0;
            end
          end else if (!width_ok) begin
            err_nxt   = rgbe_pkg::ST_WIDTH;
            state_nxt = rgbe_pkg::S_ERR;
          end else begin
            case (phase_r)
              rgbe_pkg::PH_COUNT: begin
                if (in_data_byte > rgbe_pkg::RUN_BASE) begin
                  if (CMPW'(in_data_byte - rgbe_pkg::RUN_BASE) > rem) begin
                    err_nxt   = rgbe_pkg::ST_OVERRUN;
                    state_nxt = rgbe_pkg::S_ERR;
                  end else begin
                    lit_nxt   = in_data_byte - rgbe_pkg::RUN_BASE;
                    phase_nxt = rgbe_pkg::PH_RUN;
                  end
                end else if (in_data_byte == 8'd0) begin
                  err_nxt   = rgbe_pkg::ST_ZERO_COUNT;
                  state_nxt = rgbe_pkg::S_ERR;
                end else if (CMPW'(in_data_byte) > rem) begin
                  err_nxt   = rgbe_pkg::ST_OVERRUN;
                  state_nxt = rgbe_pkg::S_ERR;
                end else begin
                  lit_nxt   = in_data_byte;
                  phase_nxt = rgbe_pkg::PH_LITERAL;
                end
              end
              rgbe_pkg::PH_RUN: begin
                if (CMPW'(lit_r) > rem) begin
                  err_nxt   = rgbe_pkg::ST_OVERRUN;
                  state_nxt = rgbe_pkg::S_ERR;
                end else begin
                  cnt_nxt   = lit_r;
                  val_nxt   = in_data_byte;
                  lit_nxt   = '0;
                  phase_nxt = rgbe_pkg::PH_COUNT;
                  state_nxt = (plane_r == rgbe_pkg::PLANE_EXP) ?
                              rgbe_pkg::S_RD1 : rgbe_pkg::S_FILL;
                end
              end
              default: begin
                if (rem == '0 || lit_r == 8'd0) begin
                  err_nxt   = rgbe_pkg::ST_OVERRUN;
                  state_nxt = rgbe_pkg::S_ERR;
                end else begin
                  cnt_nxt   = 8'd1;
                  val_nxt   = in_data_byte;
                  lit_nxt   = lit_r - 8'd1;
                  phase_nxt = (lit_r == 8'd1) ? rgbe_pkg::PH_COUNT : rgbe_pkg::PH_LITERAL;
                  state_nxt = (plane_r == rgbe_pkg::PLANE_EXP) ?
                              rgbe_pkg::S_RD1 : rgbe_pkg::S_FILL;
                end
              end
            endcase
          end
        end
      end
      // One colour byte written per cycle.
      rgbe_pkg::S_FILL: begin
        wr_en   = 1'b1;
        col_nxt = col_inc;
        cnt_nxt = cnt_r - 8'd1;
        if (cnt_r == 8'd1) begin
          state_nxt = rgbe_pkg::S_CHK;
        end
      end
      rgbe_pkg::S_RD1: begin
        rd_en     = 1'b1;
        state_nxt = rgbe_pkg::S_RD2;
      end
      // First pixel of the pair arrives; start the second read if needed.
      rgbe_pkg::S_RD2: begin
        col_nxt = col_inc;
        cnt_nxt = cnt_r - 8'd1;
        if (cnt_r > 8'd1) begin
          rd_en     = 1'b1;
          rd_addr   = col_inc[AW-1:0];
          state_nxt = rgbe_pkg::S_RD3;
        end else begin
          state_nxt = rgbe_pkg::S_EMIT;
        end
      end
      rgbe_pkg::S_RD3: begin
        col_nxt   = col_inc;
        cnt_nxt   = cnt_r - 8'd1;
        state_nxt = rgbe_pkg::S_EMIT;
      end
      rgbe_pkg::S_EMIT: begin
        if (out_free) begin
          load_pix  = 1'b1;
          state_nxt = (cnt_r == 8'd0) ? rgbe_pkg::S_CHK : rgbe_pkg::S_RD1;
        end
      end
      // End of plane and end of scanline bookkeeping.
      rgbe_pkg::S_CHK: begin
        state_nxt = rgbe_pkg::S_IDLE;
        if (phase_r == rgbe_pkg::PH_COUNT && col_ext >= iw_ext) begin
          col_nxt = '0;
          if (plane_r != rgbe_pkg::PLANE_EXP) begin
            plane_nxt = plane_r + 2'd1;
          end else begin
            plane_nxt = rgbe_pkg::PLANE_RED;
            hdr_nxt   = '0;
            line_nxt  = (line_r + 15'd1 == ih_r) ? '0 : line_r + 15'd1;
          end
        end
      end
      rgbe_pkg::S_ERR: begin
        if (out_free) begin
          load_err  = 1'b1;
          state_nxt = rgbe_pkg::S_IDLE;
        end
      end
      default: state_nxt = rgbe_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rgbe_pkg::S_IDLE;
      col_r   <= '0;
      plane_r <= rgbe_pkg::PLANE_RED;
      hdr_r   <= '0;
      whi_r   <= '0;
      phase_r <= rgbe_pkg::PH_COUNT;
      lit_r   <= '0;
      line_r  <= '0;
      err_r   <= rgbe_pkg::ST_OK;
      cnt_r   <= '0;
      iw_r    <= 13'd1024;
      ih_r    <= 15'd512;
    end else begin
      state_r <= state_nxt;
      col_r   <= col_nxt;
      plane_r <= plane_nxt;
      hdr_r   <= hdr_nxt;
      whi_r   <= whi_nxt;
      phase_r <= phase_nxt;
      lit_r   <= lit_nxt;
      line_r  <= line_nxt;
      err_r   <= err_nxt;
      cnt_r   <= cnt_nxt;
      // Configuration writes.
      if (cfg_valid && cfg_index == rgbe_pkg::CFG_IMAGE_WIDTH) begin
        iw_r <= cfg_data[12:0];
      end
      if (cfg_valid && cfg_index == rgbe_pkg::CFG_IMAGE_HEIGHT) begin
        ih_r <= cfg_data[14:0];
      end
    end
  end

  // Line store: byte-wide writes, registered read.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      case (plane_r)
        rgbe_pkg::PLANE_RED: line_mem[col_r[AW-1:0]][23:16] <= val_r;
        rgbe_pkg::PLANE_GRN: line_mem[col_r[AW-1:0]][15:8]  <= val_r;
        default:             line_mem[col_r[AW-1:0]][7:0]   <= val_r;
      endcase
    end
    if (rd_en) begin
      rd_q <= line_mem[rd_addr];
    end
  end

  // Pixel pair assembly.
  always_ff @(posedge clk) begin
    val_r <= val_nxt;
    if (state_r == rgbe_pkg::S_RD2) begin
      h0r_r  <= f_red;
      h0g_r  <= f_grn;
      h0b_r  <= f_blu;
      h0le_r <= le_now;
      h0ie_r <= ie_now;
      h1r_r  <= '0;
      h1g_r  <= '0;
      h1b_r  <= '0;
      h1le_r <= 1'b0;
      h1ie_r <= 1'b0;
      two_r  <= 1'b0;
    end else if (state_r == rgbe_pkg::S_RD3) begin
      h1r_r  <= f_red;
      h1g_r  <= f_grn;
      h1b_r  <= f_blu;
      h1le_r <= le_now;
      h1ie_r <= ie_now;
      two_r  <= 1'b1;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_pix || load_err) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
    if (load_pix) begin
      o_cnt_r  <= two_r ? 2'd2 : 2'd1;
      o0r_r    <= h0r_r;
      o0g_r    <= h0g_r;
      o0b_r    <= h0b_r;
      o1r_r    <= h1r_r;
      o1g_r    <= h1g_r;
      o1b_r    <= h1b_r;
      o_last_r <= (cnt_r == 8'd0);
      o_le_r   <= h0le_r || h1le_r;
      o_ie_r   <= h0ie_r || h1ie_r;
      o_st_r   <= rgbe_pkg::ST_OK;
    end else if (load_err) begin
      o_cnt_r  <= 2'd0;
      o0r_r    <= '0;
      o0g_r    <= '0;
      o0b_r    <= '0;
      o1r_r    <= '0;
      o1g_r    <= '0;
      o1b_r    <= '0;
      o_last_r <= 1'b1;
      o_le_r   <= 1'b0;
      o_ie_r   <= 1'b0;
      o_st_r   <= err_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_pixel_count   = o_cnt_r;
  assign out_first_red     = o0r_r;
  assign out_first_green   = o0g_r;
  assign out_first_blue    = o0b_r;
  assign out_second_red    = o1r_r;
  assign out_second_green  = o1g_r;
  assign out_second_blue   = o1b_r;
  assign out_last_of_burst = o_last_r;
  assign out_line_end      = o_le_r;
  assign out_image_end     = o_ie_r;
  assign out_status        = o_st_r;

endmodule
`default_nettype wire

[sim/rgbe_rle_scanline_decoder_unit_tb.sv]
`default_nettype none
module rgbe_rle_scanline_decoder_unit_tb;

  // Register indexes beyond the list; writes to these must have no effect.
  localparam logic [1:0] CFG_SPARE_A = 2'd2;
  localparam logic [1:0] CFG_SPARE_B = 2'd3;
  localparam int LS_DEPTH = 4096;
  localparam int EXP_BIAS = 136;

  typedef struct packed {
    logic [1:0]  cnt;
    logic [31:0] fr, fg, fb, sr, sg, sb;
    logic        last, lend, iend;
    logic [2:0]  st;
  } pixel_beat_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_data_byte = '0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = rgbe_pkg::CFG_IMAGE_WIDTH;
  logic [15:0] cfg_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  out_pixel_count;
  logic [31:0] out_first_red, out_first_green, out_first_blue;
  logic [31:0] out_second_red, out_second_green, out_second_blue;
  logic        out_last_of_burst, out_line_end, out_image_end;
  logic [2:0]  out_status;

  rgbe_rle_scanline_decoder_unit i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data_byte(in_data_byte),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_pixel_count(out_pixel_count),
    .out_first_red(out_first_red), .out_first_green(out_first_green),
    .out_first_blue(out_first_blue),
    .out_second_red(out_second_red), .out_second_green(out_second_green),
    .out_second_blue(out_second_blue),
    .out_last_of_burst(out_last_of_burst), .out_line_end(out_line_end),
    .out_image_end(out_image_end), .out_status(out_status)
  );

  always #4 clk = ~clk;

  // Decoder state as the predictor sees it.
  logic [23:0] line_rgb[LS_DEPTH];
  int          col, plane_no, hdr_seen, width_hi, phase, pending, line_no;
  logic [2:0]  sticky;
  int          img_width = 1024, img_height = 512;

  pixel_beat_t pixel_beats_q[$];
  int          fail_count = 0, bytes_sent = 0, beats_seen = 0, lines_done = 0;
  bit          tx_burst = 1'b0, rx_burst = 1'b0;

  // Exact single-precision bits of m * 2^(e - 136).
  function automatic logic [31:0] rgbe_to_float(input int m, input int e);
    int p, ex;
    if (m == 0 || e == 0) return 32'd0;
    p = 7;
    while (((m >> p) & 1) == 0) p--;
    ex = p + e - EXP_BIAS;
    if (ex >= -126) return ((ex + 127) << 23) | ((m << (23 - p)) & 32'h7F_FFFF);
    return m << (e + 13);
  endfunction

  function automatic bit width_legal();
    return img_width >= 1 && img_width <= LS_DEPTH;
  endfunction

  task automatic push_error(input logic [2:0] code);
    pixel_beat_t r;
    r = '0;
    r.last = 1'b1;
    r.st = code;
    sticky = code;
    pixel_beats_q.insert(pixel_beats_q.size(), r);
  endtask

  // Works out the beats that one accepted byte causes.
  task automatic predict_byte(input int b);
    logic [31:0] pr[128], pg[128], pb[128];
    bit          ple[128], pie[128];
    int          rem, n, reps, sh, k, a, nres;
    logic [23:0] rgb;
    pixel_beat_t r;
    bit          two;
    n = 0;
    if (sticky != rgbe_pkg::ST_OK) return;
    // Scanline header: two markers, then the width big-endian.
    if (hdr_seen < 4) begin
      if (hdr_seen < 2) begin
        if (b != rgbe_pkg::MARKER) begin
          push_error(rgbe_pkg::ST_BAD_MARKER);
          return;
        end
        hdr_seen++;
      end else if (hdr_seen == 2) begin
        width_hi = b;
        hdr_seen = 3;
      end else begin
        if (!width_legal() || ((width_hi << 8) | b) != img_width) begin
          push_error(rgbe_pkg::ST_WIDTH);
          return;
        end
        hdr_seen = 4;
        plane_no = rgbe_pkg::PLANE_RED;
        col = 0;
        phase = rgbe_pkg::PH_COUNT;
        pending = 0;
      end
      return;
    end
    if (!width_legal()) begin
      push_error(rgbe_pkg::ST_WIDTH);
      return;
    end
    rem = (col < img_width) ? img_width - col : 0;
    // Count byte: a run above the base, a literal count otherwise.
    if (phase == rgbe_pkg::PH_COUNT) begin
      if (b > rgbe_pkg::RUN_BASE) begin
        if (b - rgbe_pkg::RUN_BASE > rem) begin
          push_error(rgbe_pkg::ST_OVERRUN);
          return;
        end
        pending = b - rgbe_pkg::RUN_BASE;
        phase = rgbe_pkg::PH_RUN;
      end else if (b == 0) begin
        push_error(rgbe_pkg::ST_ZERO_COUNT);
        return;
      end else begin
        if (b > rem) begin
          push_error(rgbe_pkg::ST_OVERRUN);
          return;
        end
        pending = b;
        phase = rgbe_pkg::PH_LITERAL;
      end
      return;
    end
    if (phase == rgbe_pkg::PH_RUN) begin
      if (pending > rem) begin
        push_error(rgbe_pkg::ST_OVERRUN);
        return;
      end
      reps = pending;
      pending = 0;
      phase = rgbe_pkg::PH_COUNT;
    end else begin
      if (rem == 0 || pending == 0) begin
        push_error(rgbe_pkg::ST_OVERRUN);
        return;
      end
      reps = 1;
      pending--;
      if (pending == 0) phase = rgbe_pkg::PH_COUNT;
    end
    // Colour planes fill the line store; the exponent plane makes pixels.
    for (int i = 0; i < reps; i++) begin
      if (plane_no < rgbe_pkg::PLANE_EXP) begin
        sh = (2 - plane_no) * 8;
        line_rgb[col] = (line_rgb[col] & ~(24'hFF << sh)) | (24'(b) << sh);
      end else begin
        rgb = line_rgb[col];
        pr[n] = rgbe_to_float(int'(rgb[23:16]), b);
        pg[n] = rgbe_to_float(int'(rgb[15:8]), b);
        pb[n] = rgbe_to_float(int'(rgb[7:0]), b);
        ple[n] = (col + 1 == img_width);
        pie[n] = ple[n] && (((line_no + 1) & 16'h7FFF) == img_height);
        n++;
      end
      col++;
    end
    if (phase == rgbe_pkg::PH_COUNT && col >= img_width) begin
      col = 0;
      if (plane_no < rgbe_pkg::PLANE_EXP) plane_no++;
      else begin
        plane_no = rgbe_pkg::PLANE_RED;
        hdr_seen = 0;
        lines_done++;
        if (((line_no + 1) & 16'h7FFF) == img_height) line_no = 0;
        else line_no = (line_no + 1) & 16'h7FFF;
      end
    end
    // Two pixels per beat, in column order.
    nres = (n + 1) / 2;
    for (k = 0; k < nres; k++) begin
      a = 2 * k;
      two = (a + 1 < n);
      r = '0;
      r.cnt = two ? 2'd2 : 2'd1;
      r.fr = pr[a];
      r.fg = pg[a];
      r.fb = pb[a];
      if (two) begin
        r.sr = pr[a + 1];
        r.sg = pg[a + 1];
        r.sb = pb[a + 1];
      end
      r.last = (k + 1 == nres);
      r.lend = ple[a] || (two && ple[a + 1]);
      r.iend = pie[a] || (two && pie[a + 1]);
      r.st = rgbe_pkg::ST_OK;
      pixel_beats_q.insert(pixel_beats_q.size(), r);
    end
  endtask

  // Sends one byte after a random gap; valid stays high into the next call.
  task automatic send_byte(input int b);
    int gap;
    gap = tx_burst ? 0 : $urandom_range(0, 16);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data_byte <= b[7:0];
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_byte(b);
    bytes_sent++;
  endtask

  // Waits for every expected beat, then for the block to settle.
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pixel_beats_q.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input int value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value[15:0];
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == rgbe_pkg::CFG_IMAGE_WIDTH) img_width = value & 16'h1FFF;
    else if (idx == rgbe_pkg::CFG_IMAGE_HEIGHT) img_height = value & 16'h7FFF;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_image(input int w, input int h);
    drain();
    write_reg(rgbe_pkg::CFG_IMAGE_WIDTH, w);
    write_reg(rgbe_pkg::CFG_IMAGE_HEIGHT, h);
  endtask

  task automatic send_header(input int w);
    send_byte(rgbe_pkg::MARKER);
    send_byte(rgbe_pkg::MARKER);
    send_byte(w >> 8);
    send_byte(w & 8'hFF);
  endtask

  // Random value, with zero and full scale weighted up.
  function automatic int pick_value(input bit expo);
    case ($urandom_range(0, 7))
      0: return 0;
      1: return 255;
      2: return expo ? $urandom_range(1, 8) : 1;
      default: return $urandom_range(0, 255);
    endcase
  endfunction

  // One well-formed scanline with random runs and literals.
  task automatic send_line(input int w);
    int rem, len;
    send_header(w);
    for (int p = 0; p < 4; p++) begin
      rem = w;
      while (rem > 0) begin
        if ($urandom_range(0, 1)) begin
          len = $urandom_range(1, rem < 127 ? rem : 127);
          send_byte(rgbe_pkg::RUN_BASE + len);
          send_byte(pick_value(p == rgbe_pkg::PLANE_EXP));
        end else begin
          len = $urandom_range(1, rem < 128 ? rem : 128);
          if ($urandom_range(0, 3) == 0) len = rem < 4 ? rem : 4;
          send_byte(len);
          for (int i = 0; i < len; i++) send_byte(pick_value(p == rgbe_pkg::PLANE_EXP));
        end
        rem -= len;
      end
    end
  endtask

  // Result checker and receiver stall generator.
  int  rx_wait = 0;
  bit  rx_took = 1'b0;
  always @(posedge clk) begin
    pixel_beat_t e;
    rx_took <= rst_n && out_valid && out_ready;
    if (rst_n && out_valid && out_ready) begin
      beats_seen++;
      if (pixel_beats_q.size() == 0) begin
        $error("unexpected beat: status %0d count %0d", out_status, out_pixel_count);
        fail_count++;
      end else begin
        e = pixel_beats_q.pop_front();
        if (out_pixel_count !== e.cnt) begin
          $error("pixel_count exp %0d got %0d", e.cnt, out_pixel_count); fail_count++;
        end
        if (out_first_red !== e.fr) begin
          $error("first_red exp %h got %h", e.fr, out_first_red); fail_count++;
        end
        if (out_first_green !== e.fg) begin
          $error("first_green exp %h got %h", e.fg, out_first_green); fail_count++;
        end
        if (out_first_blue !== e.fb) begin
          $error("first_blue exp %h got %h", e.fb, out_first_blue); fail_count++;
        end
        if (out_second_red !== e.sr) begin
          $error("second_red exp %h got %h", e.sr, out_second_red); fail_count++;
        end
        if (out_second_green !== e.sg) begin
          $error("second_green exp %h got %h", e.sg, out_second_green); fail_count++;
        end
        if (out_second_blue !== e.sb) begin
          $error("second_blue exp %h got %h", e.sb, out_second_blue); fail_count++;
        end
        if (out_last_of_burst !== e.last) begin
          $error("last_of_burst exp %0d got %0d", e.last, out_last_of_burst); fail_count++;
        end
        if (out_line_end !== e.lend) begin
          $error("line_end exp %0d got %0d", e.lend, out_line_end); fail_count++;
        end
        if (out_image_end !== e.iend) begin
          $error("image_end exp %0d got %0d", e.iend, out_image_end); fail_count++;
        end
        if (out_status !== e.st) begin
          $error("status exp %0d got %0d", e.st, out_status); fail_count++;
        end
      end
    end
  end

  // A new stall is drawn after every accepted beat.
  always @(negedge clk) begin
    if (!rst_n) out_ready <= 1'b0;
    else begin
      if (rx_took) rx_wait = rx_burst ? 0 : $urandom_range(0, 16);
      if (rx_wait > 0) begin
        rx_wait--;
        out_ready <= 1'b0;
      end else out_ready <= 1'b1;
    end
  end

  // Short lines with every colour and exponent extreme, and an image end.
  task automatic test_directed();
    int lit[];
    set_image(3, 2);
    send_header(3);
    lit = '{3, 0, 255, 1, 131, 128, 130, 7, 1, 255, 1, 0, 130, 255};
    foreach (lit[i]) send_byte(lit[i]);
    send_header(3);
    lit = '{131, 255, 3, 1, 128, 85, 131, 170, 3, 1, 136, 8};
    foreach (lit[i]) send_byte(lit[i]);
  endtask

  // Register extremes, including the ignored indexes and wrap of the height.
  task automatic test_register_extremes();
    set_image(1, 1);
    write_reg(CFG_SPARE_A, 16'hFFFF);
    write_reg(CFG_SPARE_B, 16'h0005);
    repeat (2) send_line(1);
    set_image(8, 0);
    send_line(8);
    // Longest literal and longest run, back to back on both sides.
    set_image(128, 2);
    tx_burst = 1'b1;
    rx_burst = 1'b1;
    send_header(128);
    send_byte(128);
    for (int i = 0; i < 128; i++) send_byte(i * 2);
    send_byte(255); send_byte(17); send_byte(1); send_byte(0);
    send_byte(255); send_byte(0); send_byte(129); send_byte(255);
    send_byte(255); send_byte(255); send_byte(1); send_byte(1);
    tx_burst = 1'b0;
    rx_burst = 1'b0;
  endtask

  // Random scanlines under random gaps, with pauses and burst stretches.
  task automatic test_random_images();
    int w, h, start;
    start = bytes_sent;
    while (bytes_sent - start < 30) begin
      w = ($urandom_range(0, 5) == 0) ? $urandom_range(13, 24) : $urandom_range(1, 12);
      h = $urandom_range(1, 2);
      set_image(w, h);
      tx_burst = ($urandom_range(0, 3) == 0);
      rx_burst = ($urandom_range(0, 3) == 0);
      repeat ($urandom_range(1, 2 * h)) begin
        send_line(w);
        if ($urandom_range(0, 2) == 0) begin
          @(negedge clk);
          in_valid <= 1'b0;
          while (pixel_beats_q.size() != 0) @(negedge clk);
        end
      end
    end
    tx_burst = 1'b0;
    rx_burst = 1'b0;
  endtask

  // One broken stream, since an error holds until reset; then ignored noise.
  task automatic test_sticky_error();
    set_image(4, 2);
    case ($urandom_range(0, 5))
      0: send_byte($urandom_range(0, 1) ? $urandom_range(3, 255) : 0);
      1: begin
        send_byte(rgbe_pkg::MARKER);
        send_header(5);
      end
      2: begin
        write_reg(rgbe_pkg::CFG_IMAGE_WIDTH, $urandom_range(0, 1) ? 0 : 5000);
        send_header(0);
      end
      3: begin
        send_header(4);
        send_byte(0);
      end
      4: begin
        send_header(4);
        send_byte(rgbe_pkg::RUN_BASE + 5);
      end
      default: begin
        send_header(4);
        send_byte(2); send_byte(9); send_byte(9);
        send_byte(3);
      end
    endcase
    repeat (8) send_byte($urandom_range(0, 255));
  endtask

  initial begin
    col = 0; plane_no = rgbe_pkg::PLANE_RED; hdr_seen = 0; width_hi = 0;
    phase = rgbe_pkg::PH_COUNT; pending = 0; line_no = 0; sticky = rgbe_pkg::ST_OK;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_register_extremes();
    test_random_images();
    test_sticky_error();
    drain();
    $display("Sent %0d bytes over %0d scanlines; checked %0d pixel beats.",
             bytes_sent, lines_done, beats_seen);
    $display("Covered widths 1 to 128, longest runs, height wrap, stalls and a sticky error.");
    if (fail_count == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #40_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
`default_nettype wire
